>>> sv/timer_divider_prescaler_calc_unit_macros.svh
// ----------------------------------------------------------------------------
// Timer divider calculator assertion macros
// Clocked assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef TIMER_DIVIDER_PRESCALER_CALC_UNIT_MACROS_SVH
`define TIMER_DIVIDER_PRESCALER_CALC_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TDPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TDPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TDPC_ASSERT_SAME(label, ante, cons)
`define TDPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// Timer divider calculator package
// Shared widths, item types, prescaler codes and the unit factor table.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpc_pkg;

    localparam int FREQ_W      = 24;
    localparam int UNIT_W      = 2;
    localparam int CODE_W      = 3;
    localparam int CMP_W       = 16;
    localparam int ACT_W       = 25;
    localparam int FACT_W      = 30;
    localparam int CNT_W       = 17;
    localparam int MAX_SHIFT   = 10;
    localparam int SHIFT_W     = 4;
    localparam int DEN1_W      = FACT_W + FREQ_W;
    localparam int DEN2_W      = FACT_W + CNT_W + MAX_SHIFT;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(17'h10000);
    localparam logic [ACT_W-1:0] ACT_MAX     = {ACT_W{1'b1}};

    localparam int DEF_CLOCK_HZ      = 16000000;
    localparam int DEF_FRACTION_BITS = 10;

    typedef enum logic [CODE_W-1:0] {
        PSC_DIV1    = 3'd0,
        PSC_DIV8    = 3'd1,
        PSC_DIV64   = 3'd2,
        PSC_DIV256  = 3'd3,
        PSC_DIV1024 = 3'd4
    } t_psc;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_q10;
        logic [UNIT_W-1:0] unit_index;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] prescaler_code;
        logic [CMP_W-1:0]  compare_value;
        logic              too_fast;
        logic [ACT_W-1:0]  actual_freq_q10;
    } t_out_item;

    typedef struct packed {
        logic [DEN1_W-1:0] den;
        logic [UNIT_W-1:0] unit_index;
    } t_job;

    typedef struct packed {
        t_psc             code;
        logic [CNT_W-1:0] count;
        logic             too_fast;
    } t_sel;

    function automatic logic [FACT_W-1:0] unit_factor(input logic [UNIT_W-1:0] idx);
        logic [FACT_W-1:0] f;
        case (idx)
            2'd0:    f = FACT_W'(1);
            2'd1:    f = FACT_W'(1000);
            2'd2:    f = FACT_W'(1000000);
            default: f = FACT_W'(1000000000);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

>>> sv/tdpc_front.sv
// ----------------------------------------------------------------------------
// Timer divider calculator front end
// Accepts a request and registers the divisor factor * frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  tdpc_pkg::t_in_item  i_item,
    output logic                o_full,
    input  wire                 i_q_full,
    output logic                o_q_push,
    output tdpc_pkg::t_job      o_job
);
    import tdpc_pkg::*;

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic load;

    assign o_full   = r_valid && i_q_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_job    = r_job;
    assign load     = !o_full;

    always_comb begin
        n_job.den        = DEN1_W'(unit_factor(i_item.unit_index)) * DEN1_W'(i_item.freq_q10);
        n_job.unit_index = i_item.unit_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_push) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

>>> sv/tdpc_queue.sv
// ----------------------------------------------------------------------------
// Timer divider calculator job queue
// Small FIFO between the front end and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  tdpc_pkg::t_job  i_data,
    output logic            o_full,
    input  wire             i_pop,
    output tdpc_pkg::t_job  o_data,
    output logic            o_empty
);
    import tdpc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == (PTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/tdpc_div.sv
// ----------------------------------------------------------------------------
// Timer divider calculator pipelined divider
// Restoring division of a constant numerator, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_div #(
    parameter int          NUM_W = 43,
    parameter logic [63:0] NUM   = 64'd1,
    parameter int          DEN_W = 54,
    parameter int          SB_W  = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  wire  [DEN_W-1:0]  i_den,
    input  wire  [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SB_W-1:0]   o_sb
);
    logic             r_valid [NUM_W];
    logic [DEN_W-1:0] r_rem   [NUM_W];
    logic [DEN_W-1:0] r_den   [NUM_W];
    logic [NUM_W-1:0] r_quot  [NUM_W];
    logic [SB_W-1:0]  r_sb    [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             p_valid;
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [NUM_W-1:0] p_quot;
        logic [SB_W-1:0]  p_sb;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_den   = i_den;
            assign p_quot  = '0;
            assign p_sb    = i_sb;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_den   = r_den[k-1];
            assign p_quot  = r_quot[k-1];
            assign p_sb    = r_sb[k-1];
        end

        assign trial = {p_rem, NUM[NUM_W-1-k]};
        assign ge    = trial >= {1'b0, p_den};
        assign diff  = ge ? (trial - {1'b0, p_den}) : trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= diff[DEN_W-1:0];
                r_den[k]  <= p_den;
                r_quot[k] <= {p_quot[NUM_W-2:0], ge};
                r_sb[k]   <= p_sb;
            end
        end
    end

    assign o_valid = r_valid[NUM_W-1];
    assign o_quot  = r_quot[NUM_W-1];
    assign o_sb    = r_sb[NUM_W-1];

endmodule

`default_nettype wire

>>> sv/tdpc_back.sv
// ----------------------------------------------------------------------------
// Timer divider calculator back end
// Count division, prescaler selection, actual frequency and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_back #(
    parameter int CLOCK_HZ      = tdpc_pkg::DEF_CLOCK_HZ,
    parameter int FRACTION_BITS = tdpc_pkg::DEF_FRACTION_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  tdpc_pkg::t_job       i_job,
    output logic                 o_take,
    input  wire                  i_pop,
    output logic                 o_empty,
    output tdpc_pkg::t_out_item  o_result
);
    import tdpc_pkg::*;

    localparam logic [63:0] NUM   = (64'(CLOCK_HZ) * 64'd500) << FRACTION_BITS;
    localparam int          NUM_W = $clog2(NUM + 64'd1);
    localparam int          SC_W  = CNT_W + MAX_SHIFT;

    logic adv;

    logic r_b0_valid;
    t_job r_b0_job;

    logic              d1_valid;
    logic [NUM_W-1:0]  d1_quot;
    logic [UNIT_W-1:0] d1_unit;

    logic [NUM_W-1:0]   n_cnt;
    t_sel               n_sel;
    logic [SHIFT_W-1:0] n_shift;

    logic               r_s1_valid;
    t_sel               r_s1_sel;
    logic [SHIFT_W-1:0] r_s1_shift;
    logic [UNIT_W-1:0]  r_s1_unit;

    logic              r_s2_valid;
    t_sel              r_s2_sel;
    logic [DEN2_W-1:0] r_s2_den;

    logic             d2_valid;
    logic [NUM_W-1:0] d2_quot;
    t_sel             d2_sel;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    assign adv      = !r_out_valid || i_pop;
    assign o_take   = adv;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid <= 1'b0;
        end else if (adv) begin
            r_b0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b0_job <= i_job;
        end
    end

    tdpc_div #(
        .NUM_W (NUM_W),
        .NUM   (NUM),
        .DEN_W (DEN1_W),
        .SB_W  (UNIT_W)
    ) u_div_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_b0_valid),
        .i_den   (r_b0_job.den),
        .i_sb    (r_b0_job.unit_index),
        .o_valid (d1_valid),
        .o_quot  (d1_quot),
        .o_sb    (d1_unit)
    );

    always_comb begin
        n_cnt          = d1_quot;
        n_sel.too_fast = d1_quot == '0;
        n_sel.code     = PSC_DIV1;
        n_shift        = SHIFT_W'(0);
        if (n_sel.too_fast) begin
            n_cnt = NUM_W'(1);
        end
        if (n_cnt > NUM_W'(COUNT_LIMIT)) begin
            n_cnt      = n_cnt >> 3;
            n_sel.code = PSC_DIV8;
            n_shift    = SHIFT_W'(3);
            if (n_cnt > NUM_W'(COUNT_LIMIT)) begin
                n_cnt      = n_cnt >> 3;
                n_sel.code = PSC_DIV64;
                n_shift    = SHIFT_W'(6);
                if (n_cnt > NUM_W'(COUNT_LIMIT)) begin
                    n_cnt      = n_cnt >> 2;
                    n_sel.code = PSC_DIV256;
                    n_shift    = SHIFT_W'(8);
                    if (n_cnt > NUM_W'(COUNT_LIMIT)) begin
                        n_cnt      = n_cnt >> 2;
                        n_sel.code = PSC_DIV1024;
                        n_shift    = SHIFT_W'(10);
                        if (n_cnt > NUM_W'(COUNT_LIMIT)) begin
                            n_cnt = NUM_W'(COUNT_LIMIT);
                        end
                    end
                end
            end
        end
        n_sel.count = n_cnt[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= d1_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_sel   <= n_sel;
            r_s1_shift <= n_shift;
            r_s1_unit  <= d1_unit;
            r_s2_sel   <= r_s1_sel;
            r_s2_den   <= DEN2_W'(unit_factor(r_s1_unit))
                        * DEN2_W'(SC_W'(r_s1_sel.count) << r_s1_shift);
        end
    end

    tdpc_div #(
        .NUM_W (NUM_W),
        .NUM   (NUM),
        .DEN_W (DEN2_W),
        .SB_W  ($bits(t_sel))
    ) u_div_actual (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s2_valid),
        .i_den   (r_s2_den),
        .i_sb    (r_s2_sel),
        .o_valid (d2_valid),
        .o_quot  (d2_quot),
        .o_sb    (d2_sel)
    );

    always_comb begin
        n_out.prescaler_code = d2_sel.code;
        n_out.compare_value  = CMP_W'(d2_sel.count - CNT_W'(1));
        n_out.too_fast       = d2_sel.too_fast;
        if (d2_quot > NUM_W'(ACT_MAX)) begin
            n_out.actual_freq_q10 = ACT_MAX;
        end else begin
            n_out.actual_freq_q10 = d2_quot[ACT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> sv/timer_divider_prescaler_calc_unit.sv
// ----------------------------------------------------------------------------
// Timer divider and prescaler calculator
// Turns a requested toggle frequency (Q10, unit mHz/Hz/kHz/MHz) into a timer
// prescaler code, compare value, too-fast flag and achieved frequency.
//
// Request channel: drive i_item and push; the item is taken on a clock edge
// where push is high and full is low. Result channel: while empty is low the
// oldest result sits on o_result; pop takes it on the same kind of edge.
// One result per request, in request order.
// Throughput: one request per cycle while full is low. Path: front register,
// queue, input register, count divider, s1, s2, actual-frequency divider and
// result register. Quotients have NUM_W bits, one per divider stage; NUM_W
// is the width of CLOCK_HZ*500*2^FRACTION_BITS (43 at defaults). When pop
// stays low the back end holds, a four-entry queue fills, and full rises.
// Synchronous reset empties every stage; results in flight are lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_divider_prescaler_calc_unit_macros.svh"

module timer_divider_prescaler_calc_unit #(
    parameter int CLOCK_HZ      = tdpc_pkg::DEF_CLOCK_HZ,
    parameter int FRACTION_BITS = tdpc_pkg::DEF_FRACTION_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    input  tdpc_pkg::t_in_item   i_item,
    output logic                 full,
    input  wire                  pop,
    output logic                 empty,
    output tdpc_pkg::t_out_item  o_result
);
    import tdpc_pkg::*;

    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_take;
    t_job f_job;
    t_job q_job;

    tdpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_job    (f_job)
    );

    tdpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    tdpc_back #(
        .CLOCK_HZ      (CLOCK_HZ),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_job    (q_job),
        .o_take   (q_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

    `TDPC_ASSERT_SAME(a_code_range, !empty, o_result.prescaler_code <= PSC_DIV1024)
    `TDPC_ASSERT_SAME(a_too_fast_min, !empty && o_result.too_fast, o_result.compare_value == '0 && o_result.prescaler_code == PSC_DIV1)
    `TDPC_ASSERT_SAME(a_scaled_floor, !empty && o_result.prescaler_code != PSC_DIV1, o_result.compare_value >= 16'd8191)

endmodule

`default_nettype wire

>>> sim/tb_timer_divider_prescaler_calc_unit.sv
// ----------------------------------------------------------------------------
// Timer divider calculator testbench
// Pushes directed and random frequency requests through the calculator,
// predicts prescaler, compare value, too-fast flag and achieved frequency for
// each or takes them from directed rows marked fixed, and compares every
// popped result in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timer_divider_prescaler_calc_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tdpc_pkg::*;

    localparam int CLOCK_HZ      = DEF_CLOCK_HZ;
    localparam int FRACTION_BITS = DEF_FRACTION_BITS;
    localparam int N_RANDOM      = 400;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        t_in_item  req;
        bit        fixed;
        t_out_item res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    t_in_item   i_item = '0;
    logic       full;
    logic       pop = 1'b0;
    logic       empty;
    t_out_item  o_result;

    t_out_item  pending_results[$];
    int         n_errors = 0;
    int         n_checked = 0;
    int         n_too_fast = 0;
    int         n_sat = 0;
    longint     cycles = 0;
    bit         stim_done = 1'b0;
    int         code_seen[5];

    timer_divider_prescaler_calc_unit #(
        .CLOCK_HZ(CLOCK_HZ),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .i_item(i_item),
        .full(full),
        .pop(pop),
        .empty(empty),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out_item calc_timer_setting(t_in_item req);
        logic [127:0] scaled;
        logic [127:0] factor;
        logic [127:0] count;
        logic [127:0] actual;
        t_psc         code;
        int           shift;
        t_out_item    res;
        scaled = 128'(CLOCK_HZ) * 500 << FRACTION_BITS;
        case (req.unit_index)
            2'd0:    factor = 1;
            2'd1:    factor = 1000;
            2'd2:    factor = 1000000;
            default: factor = 1000000000;
        endcase
        code = PSC_DIV1;
        shift = 0;
        res = '0;
        if (req.freq_q10 == 0) count = {64{1'b1}};
        else count = scaled / (factor * req.freq_q10);
        if (count == 0) begin
            res.too_fast = 1'b1;
            count = 1;
        end
        if (count > 65536) begin
            count = count >> 3; code = PSC_DIV8; shift = 3;
            if (count > 65536) begin
                count = count >> 3; code = PSC_DIV64; shift = 6;
                if (count > 65536) begin
                    count = count >> 2; code = PSC_DIV256; shift = 8;
                    if (count > 65536) begin
                        count = count >> 2; code = PSC_DIV1024; shift = 10;
                        if (count > 65536) count = 65536;
                    end
                end
            end
        end
        actual = scaled / (factor * (count << shift));
        if (actual > 128'(ACT_MAX)) actual = 128'(ACT_MAX);
        res.prescaler_code = code;
        res.compare_value = CMP_W'(count - 1);
        res.actual_freq_q10 = ACT_W'(actual);
        return res;
    endfunction

    function automatic t_row mk_row(logic [FREQ_W-1:0] f, logic [UNIT_W-1:0] u, bit fixed,
                                    t_psc c, logic [CMP_W-1:0] cv, logic tf,
                                    logic [ACT_W-1:0] a);
        t_row r;
        r.req.freq_q10 = f;
        r.req.unit_index = u;
        r.fixed = fixed;
        r.res.prescaler_code = c;
        r.res.compare_value = cv;
        r.res.too_fast = tf;
        r.res.actual_freq_q10 = a;
        return r;
    endfunction

    task automatic send_request(t_in_item req);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            push <= 1'b0;
            i_item <= '{freq_q10: FREQ_W'($urandom), unit_index: UNIT_W'($urandom)};
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_row     rows[$];
        t_in_item req;
        t_out_item exp_res;
        int       pick;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rows.push_back(mk_row(24'd0, 2'd0, 1, PSC_DIV1024, 16'hFFFF, 1'b0, 25'd122070));
        rows.push_back(mk_row(24'd0, 2'd3, 1, PSC_DIV1024, 16'hFFFF, 1'b0, 25'd0));
        rows.push_back(mk_row(24'hFFFFFF, 2'd3, 1, PSC_DIV1, 16'd0, 1'b1, 25'd8192));
        rows.push_back(mk_row(24'd1, 2'd0, 1, PSC_DIV1024, 16'hFFFF, 1'b0, 25'd122070));
        rows.push_back(mk_row(24'hFFFFFF, 2'd0, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'hFFFFFF, 2'd1, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'hFFFFFF, 2'd2, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd1, 2'd1, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd1, 2'd2, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd1, 2'd3, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd1024, 2'd1, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd1024, 2'd2, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd8192, 2'd3, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd8193, 2'd3, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd125000, 2'd0, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd125, 2'd1, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd15625, 2'd0, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd2000, 2'd1, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd3, 2'd1, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'd40, 2'd2, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'haaaaaa, 2'd1, 0, PSC_DIV1, 0, 0, 0));
        rows.push_back(mk_row(24'h555555, 2'd0, 0, PSC_DIV1, 0, 0, 0));

        foreach (rows[i]) begin
            exp_res = rows[i].fixed ? rows[i].res : calc_timer_setting(rows[i].req);
            pending_results.push_back(exp_res);
            send_request(rows[i].req);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 3);
            req.unit_index = UNIT_W'($urandom_range(0, 3));
            case (pick)
                0: req.freq_q10 = FREQ_W'($urandom);
                1: req.freq_q10 = FREQ_W'($urandom) >> $urandom_range(0, 23);
                2: req.freq_q10 = FREQ_W'($urandom_range(0, 40));
                default: req.freq_q10 = FREQ_W'($urandom_range(1, 20000));
            endcase
            pending_results.push_back(calc_timer_setting(req));
            send_request(req);
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin : pop_side
        int wait_n;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_n = $urandom_range(0, 13);
            if ($urandom_range(0, 2) == 0) wait_n = 0;
            if (wait_n > 0) begin
                pop <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", o_result);
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (exp_res.too_fast) n_too_fast++;
                if (exp_res.actual_freq_q10 == ACT_MAX) n_sat++;
                code_seen[exp_res.prescaler_code]++;
                if (o_result.prescaler_code !== exp_res.prescaler_code) begin
                    $error("prescaler_code exp %0d got %0d",
                           exp_res.prescaler_code, o_result.prescaler_code);
                    n_errors++;
                end
                if (o_result.compare_value !== exp_res.compare_value) begin
                    $error("compare_value exp %0d got %0d",
                           exp_res.compare_value, o_result.compare_value);
                    n_errors++;
                end
                if (o_result.too_fast !== exp_res.too_fast) begin
                    $error("too_fast exp %0d got %0d", exp_res.too_fast, o_result.too_fast);
                    n_errors++;
                end
                if (o_result.actual_freq_q10 !== exp_res.actual_freq_q10) begin
                    $error("actual_freq_q10 exp %0d got %0d",
                           exp_res.actual_freq_q10, o_result.actual_freq_q10);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT && !(stim_done && pending_results.size() == 0)) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
        end else begin
            repeat (200) @(posedge i_clk);
            $display("Checked %0d results: %0d too fast, %0d saturated, by prescaler %0d/%0d/%0d/%0d/%0d.",
                     n_checked, n_too_fast, n_sat, code_seen[0], code_seen[1],
                     code_seen[2], code_seen[3], code_seen[4]);
            if (n_errors == 0) begin
                $display("No mismatches found");
            end else begin
                $display("Mismatches found");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
